@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising clk_i edge, off during reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent in a cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/kmst_pkg.sv @@
// ----------------------------------------------------------------------------
// kmst_pkg
// Key codes, entry places and keypad decode for the m:ss timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmst_pkg;

  localparam logic [3:0] KEY_9    = 4'd9;
  localparam logic [3:0] KEY_A    = 4'd10;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_C    = 4'd12;
  localparam logic [3:0] KEY_D    = 4'd13;
  localparam logic [3:0] KEY_NONE = 4'd14;

  localparam logic [1:0] PLACE_MIN  = 2'd0;
  localparam logic [1:0] PLACE_TENS = 2'd1;
  localparam logic [1:0] PLACE_ONES = 2'd2;

  localparam logic [3:0] ONES_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX = 3'd5;
  localparam logic [3:0] MIN_MAX  = 4'd9;
  localparam logic [3:0] TENS_LIM = 4'd6;

  // row 0: 1 2 3 A / row 1: 4 5 6 B / row 2: 7 8 9 C / row 3: * 0 # D
  function automatic logic [3:0] key_decode(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] k;
    k = KEY_NONE;
    case (row)
      2'd0: k = (col == 2'd3) ? KEY_A : 4'({2'b00, col} + 4'd1);
      2'd1: k = (col == 2'd3) ? KEY_B : 4'({2'b00, col} + 4'd4);
      2'd2: k = (col == 2'd3) ? KEY_C : 4'({2'b00, col} + 4'd7);
      default: begin
        case (col)
          2'd1:    k = 4'd0;
          2'd3:    k = KEY_D;
          default: k = KEY_NONE;
        endcase
      end
    endcase
    return k;
  endfunction

  function automatic logic [9:0] total_seconds(input logic [3:0] m, input logic [2:0] t,
                                               input logic [3:0] o);
    return 10'({6'd0, m} * 10'd60) + 10'({7'd0, t} * 10'd10) + {6'd0, o};
  endfunction

endpackage

@@ hdl/keypad_minute_second_timer.sv @@
// ----------------------------------------------------------------------------
// keypad_minute_second_timer
// m:ss timer driven by keypad and one-second tick requests.
// ----------------------------------------------------------------------------
// channel  | dir | tdata                                      | tuser
// s_axis   | in  | [1:0] key_row, [3:2] key_col, [7:4] zero   | [0] action
// m_axis   | out | [3:0] minute, [6:4] tens, [10:7] ones,     | -
//          |     | [11] running, [12] entering, [13] alarm    |
// cfg      | in  | cfg_wdata_i = count_down, written on cfg_we_i
//
// Input register, then decode and digit update into the state and result
// registers. One request per cycle sustained while the output is not stalled.
// A stalled result holds the input register; a new request is still taken
// while the result register drains in the same cycle.
// Reset clears all control and timer state; count_down resets to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_minute_second_timer
  import kmst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] key_row, [3:2] key_col
  input  logic [0:0]  s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // minute, tens, ones, running, entering, alarm
);

  logic       count_down_q;
  logic       in_valid_q;
  logic       in_tick_q;
  logic [1:0] in_row_q, in_col_q;
  logic       out_valid_q;
  logic [15:0] out_data_q;

  logic [3:0] minutes_q, minutes_d;
  logic [2:0] tens_q, tens_d;
  logic [3:0] ones_q, ones_d;
  logic [9:0] remain_q, remain_d;
  logic [1:0] place_q, place_d;
  logic       entering_q, entering_d;
  logic       running_q, running_d;
  logic       alarm_q, alarm_d;

  logic       advance;
  logic [3:0] key;
  logic       recompute;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign key           = key_decode(in_row_q, in_col_q);

  always_comb begin
    minutes_d  = minutes_q;
    tens_d     = tens_q;
    ones_d     = ones_q;
    remain_d   = remain_q;
    place_d    = place_q;
    entering_d = entering_q;
    running_d  = running_q;
    alarm_d    = alarm_q;
    recompute  = 1'b0;
    if (in_tick_q) begin
      if (running_q) begin
        if (remain_q != '0) begin
          remain_d = remain_q - 10'd1;
          if (count_down_q) begin
            if (ones_q != '0) begin
              ones_d = ones_q - 4'd1;
            end else if (tens_q != '0) begin
              ones_d = ONES_MAX;
              tens_d = tens_q - 3'd1;
            end else begin
              minutes_d = (minutes_q == '0) ? MIN_MAX : minutes_q - 4'd1;
              tens_d    = TENS_MAX;
              ones_d    = ONES_MAX;
            end
          end else begin
            if (ones_q < ONES_MAX) begin
              ones_d = ones_q + 4'd1;
            end else if (tens_q < TENS_MAX) begin
              ones_d = '0;
              tens_d = tens_q + 3'd1;
            end else begin
              ones_d    = '0;
              tens_d    = '0;
              minutes_d = (minutes_q >= MIN_MAX) ? '0 : minutes_q + 4'd1;
            end
          end
        end else begin
          alarm_d = 1'b1;
        end
      end
    end else if (key <= KEY_9) begin
      if (entering_q) begin
        case (place_q)
          PLACE_TENS: begin
            if (key < TENS_LIM) begin
              tens_d    = key[2:0];
              place_d   = PLACE_ONES;
              recompute = 1'b1;
            end
          end
          PLACE_ONES: begin
            ones_d    = key;
            place_d   = PLACE_MIN;
            recompute = 1'b1;
          end
          default: begin
            minutes_d = key;
            place_d   = PLACE_TENS;
            recompute = 1'b1;
          end
        endcase
      end
    end else begin
      case (key)
        KEY_A: begin
          entering_d = 1'b0;
          running_d  = 1'b1;
        end
        KEY_B: running_d = 1'b0;
        KEY_D: begin
          minutes_d  = '0;
          tens_d     = '0;
          ones_d     = '0;
          remain_d   = '0;
          place_d    = PLACE_MIN;
          entering_d = 1'b1;
          running_d  = 1'b0;
          alarm_d    = 1'b0;
        end
        default: ;
      endcase
    end
    if (recompute) begin
      remain_d = total_seconds(minutes_d, tens_d, ones_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_down_q <= 1'b1;
    end else if (cfg_we_i) begin
      count_down_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_tick_q <= s_axis_tuser[0];
      in_row_q  <= s_axis_tdata[1:0];
      in_col_q  <= s_axis_tdata[3:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minutes_q   <= '0;
      tens_q      <= '0;
      ones_q      <= '0;
      remain_q    <= '0;
      place_q     <= PLACE_MIN;
      entering_q  <= 1'b0;
      running_q   <= 1'b0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        minutes_q  <= minutes_d;
        tens_q     <= tens_d;
        ones_q     <= ones_d;
        remain_q   <= remain_d;
        place_q    <= place_d;
        entering_q <= entering_d;
        running_q  <= running_d;
        alarm_q    <= alarm_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, alarm_d, entering_d, running_d, ones_d, tens_d, minutes_d};
    end
  end

  `ASSERT_CLK(a_digits_range, (tens_q <= TENS_MAX) && (ones_q <= ONES_MAX) && (minutes_q <= MIN_MAX), "digit out of range")
  `ASSERT_CLK(a_mode_excl, !(entering_q && running_q), "entering and running together")
  `ASSERT_CLK(a_alarm_src, $rose(alarm_q) |-> $past(advance && in_tick_q && running_q), "alarm without running tick")
  `ASSERT_CLK(a_out_src, $rose(out_valid_q) |-> $past(advance), "result without request")
  `ASSERT_NEXT(a_hold, in_valid_q && !advance, in_valid_q && $stable(key), "request lost under stall")

endmodule

@@ tb/tb_keypad_minute_second_timer.sv @@
// ----------------------------------------------------------------------------
// tb_keypad_minute_second_timer
// Self-checking bench for the m:ss keypad timer. Key and tick requests go in
// on the input stream in random bursts while the output side stalls on its
// own pattern. A tracker class keeps its own timer state, predicts the
// display after every accepted request and checks each result in order.
// A directed opening covers every key, entry rules, alarm and minute wrap.
// Random sessions follow under both count directions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keypad_minute_second_timer
  import kmst_pkg::*;
;

  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic       alarm;
    logic       entering;
    logic       running;
    logic [3:0] ones;
    logic [2:0] tens;
    logic [3:0] minute;
  } display_t;

  class countdown_tracker;
    logic       count_down = 1'b1;
    logic [3:0] minutes    = '0;
    logic [2:0] tens       = '0;
    logic [3:0] ones       = '0;
    logic [9:0] remaining  = '0;
    logic [1:0] place      = PLACE_MIN;
    logic       entering   = 1'b0;
    logic       running    = 1'b0;
    logic       alarm      = 1'b0;
    display_t   due_displays[$];
    int unsigned errors, ticks, keys, displays, alarm_displays;

    function logic [3:0] keypad_code(logic [1:0] row, logic [1:0] col);
      if (row == 2'd3) return (col == 2'd1) ? 4'd0 : (col == 2'd3) ? KEY_D : KEY_NONE;
      if (col == 2'd3) return (row == 2'd0) ? KEY_A : (row == 2'd1) ? KEY_B : KEY_C;
      return 4'(3 * row + col + 1);
    endfunction

    function void note_request(logic act, logic [1:0] row, logic [1:0] col);
      logic [3:0] key;
      display_t   d;
      key = keypad_code(row, col);
      if (act) begin
        ticks++;
        if (running && remaining == 0) begin
          alarm = 1'b1;
        end else if (running) begin
          remaining--;
          if (count_down) begin
            if (ones != 0) begin
              ones--;
            end else if (tens != 0) begin
              ones = ONES_MAX;
              tens--;
            end else begin
              minutes = (minutes == 0) ? MIN_MAX : minutes - 4'd1;
              tens    = TENS_MAX;
              ones    = ONES_MAX;
            end
          end else begin
            if (ones < ONES_MAX) begin
              ones++;
            end else if (tens < TENS_MAX) begin
              ones = '0;
              tens++;
            end else begin
              ones    = '0;
              tens    = '0;
              minutes = (minutes >= MIN_MAX) ? 4'd0 : minutes + 4'd1;
            end
          end
        end
      end else begin
        keys++;
        if (key <= KEY_9) begin
          if (entering && !(place == PLACE_TENS && key >= TENS_LIM)) begin
            case (place)
              PLACE_TENS: begin
                tens  = key[2:0];
                place = PLACE_ONES;
              end
              PLACE_ONES: begin
                ones  = key;
                place = PLACE_MIN;
              end
              default: begin
                minutes = key;
                place   = PLACE_TENS;
              end
            endcase
            remaining = 10'(minutes * 60 + tens * 10 + ones);
          end
        end else if (key == KEY_A) begin
          entering = 1'b0;
          running  = 1'b1;
        end else if (key == KEY_B) begin
          running = 1'b0;
        end else if (key == KEY_D) begin
          minutes   = '0;
          tens      = '0;
          ones      = '0;
          remaining = '0;
          place     = PLACE_MIN;
          entering  = 1'b1;
          running   = 1'b0;
          alarm     = 1'b0;
        end
      end
      d.minute   = minutes;
      d.tens     = tens;
      d.ones     = ones;
      d.running  = running;
      d.entering = entering;
      d.alarm    = alarm;
      due_displays.push_back(d);
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("ERROR %0t ns display %0d: %s got %0d want %0d", $time, displays, what, got,
               want);
      errors++;
    endtask

    task check_display(logic [15:0] data);
      display_t got, want;
      got = display_t'(data[13:0]);
      if (due_displays.size() == 0) begin
        flag_mismatch("display with no request pending", data, 0);
        return;
      end
      want = due_displays.pop_front();
      displays++;
      if (got.alarm) alarm_displays++;
      if (got.minute !== want.minute)     flag_mismatch("minute", got.minute, want.minute);
      if (got.tens !== want.tens)         flag_mismatch("tens", got.tens, want.tens);
      if (got.ones !== want.ones)         flag_mismatch("ones", got.ones, want.ones);
      if (got.running !== want.running)   flag_mismatch("running", got.running, want.running);
      if (got.entering !== want.entering) flag_mismatch("entering", got.entering, want.entering);
      if (got.alarm !== want.alarm)       flag_mismatch("alarm", got.alarm, want.alarm);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [1:0] key_row, [3:2] key_col, [7:4] zero
  logic [0:0]  s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // minute, tens, ones, running, entering, alarm

  countdown_tracker sb;
  int unsigned      sent;
  int unsigned      burst_left;
  bit               hold_off_req;

  keypad_minute_second_timer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(logic act, logic [1:0] row, logic [1:0] col);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, col, row};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, row, col);
    sent++;
  endtask

  task automatic press(logic [1:0] row, logic [1:0] col);
    send_request(1'b0, row, col);
  endtask

  task automatic tick();
    send_request(1'b1, 2'($urandom), 2'($urandom));
  endtask

  task automatic press_digit(int d);
    if (d == 0) press(2'd3, 2'd1);
    else press(2'((d - 1) / 3), 2'((d - 1) % 3));
  endtask

  // idle the input, let all displays come back, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.due_displays.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count_down(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.count_down = v;
  endtask

  // mostly clear / enter / start / tick sessions, some random noise requests
  task automatic run_sessions(int unsigned quota);
    int unsigned stop_at, runs;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        press(2'd3, 2'd3);
        press_digit(($urandom_range(0, 99) < 60) ? 0 : $urandom_range(0, 9));
        if ($urandom_range(0, 9) == 0) press_digit($urandom_range(6, 9));
        press_digit($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 5));
        press_digit($urandom_range(0, 9));
        if ($urandom_range(0, 9) == 0) press_digit($urandom_range(0, 9));
        press(2'd0, 2'd3);
        runs = $urandom_range(1, 40);
        repeat (runs) begin
          if ($urandom_range(0, 29) == 0) press(2'd1, 2'd3);
          else if ($urandom_range(0, 29) == 0) press(2'd0, 2'd3);
          else tick();
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_request(1'($urandom), 2'($urandom), 2'($urandom));
      end
    end
  endtask

  // output side: random stall modes, plus one long hold-off on request
  initial begin
    int unsigned mode, mode_left;
    logic        rdy;
    m_axis_tready = 1'b0;
    mode_left     = 0;
    rdy           = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ~rdy;
        endcase
        m_axis_tready <= rdy;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_display(m_axis_tdata);
    end
  end

  initial begin
    sb            = new();
    sent          = 0;
    burst_left    = 0;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, ignored digit, dead keys, start at zero, alarm
    tick();
    press(2'd1, 2'd1);
    press(2'd2, 2'd3);
    press(2'd3, 2'd0);
    press(2'd3, 2'd2);
    press(2'd0, 2'd3);
    tick();
    press(2'd1, 2'd3);
    // entry: 9, tens 6..8 rejected, 5, 9, then wrap back to minutes
    press(2'd3, 2'd3);
    press_digit(9);
    press_digit(6);
    press_digit(7);
    press_digit(8);
    press_digit(5);
    press_digit(9);
    press_digit(0);
    press_digit(4);
    press_digit(3);
    press_digit(1);
    press_digit(2);
    press(2'd0, 2'd3);
    tick();
    press(2'd1, 2'd3);
    tick();
    press(2'd0, 2'd3);
    settle();

    // 9:59 counting up wraps to 0:00, then counting down wraps to 9:59
    set_count_down(1'b0);
    press(2'd3, 2'd3);
    press_digit(9);
    press_digit(5);
    press_digit(9);
    press(2'd0, 2'd3);
    tick();
    tick();
    settle();
    set_count_down(1'b1);
    tick();
    tick();
    press(2'd1, 2'd3);
    settle();

    hold_off_req = 1'b1;
    set_count_down(1'b0);
    run_sessions(400);
    settle();
    set_count_down(1'b1);
    run_sessions(400);
    settle();
    set_count_down(1'b0);
    run_sessions(400);
    settle();
    set_count_down(1'b1);
    run_sessions(400);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests (%0d ticks, %0d keys), %0d displays, %0d with alarm.",
             sent, sb.ticks, sb.keys, sb.displays, sb.alarm_displays);
    $display("Both count directions, minute wrap each way, and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
